[hw/rtl/assert_macros.svh]
// Assertion macros used by the PID step engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also applies during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pidc_pkg.sv]
// Shared types and constants of the PID step engine.
package pidc_pkg;

  // Action selected by each request
  typedef enum logic [1:0] {
    MODE_RUN       = 2'd0,
    MODE_INTEGRATE = 2'd1,
    MODE_DIFF      = 2'd2,
    MODE_RESTART   = 2'd3
  } mode_t;

  // Control that travels with an item between pipeline stages
  typedef struct packed {
    logic  valid;
    mode_t mode;
  } item_ctl_t;

  // Configuration register layout
  localparam int GAIN_W     = 24;
  localparam int BOUND_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_MAX = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 24'd65536;
  localparam logic [BOUND_W-1:0] INT_MIN_RESET = 16'd0;
  localparam logic [BOUND_W-1:0] INT_MAX_RESET = 16'd1;

endpackage

[hw/rtl/pid_step_with_clamped_integral.sv]
// Top level of the PID step engine: ports, configuration registers, pipeline.
//
//   channel | direction | tdata                            | tuser
//   in_     | request   | process_value, set_point         | mode
//   out_    | result     | drive (zero padded)              | -
//   cfg_    | write      | register value, index in cfg_index | -
//
// Three-stage pipeline: input register, product register (error times gain),
// state/output register. One request per cycle while out_tready is high; a
// result passes through the input, product and state/output registers in turn.
// The error multiply has a stage of its own, which sets the pipeline depth.
// Reset (rst_n low, synchronous) clears all controller state, restores the
// register defaults and empties the pipeline. Each stage holds while the next
// one is full and stalled, so back-pressure on out_ reaches in_tready only
// once every stage is occupied.
module pid_step_with_clamped_integral #(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: process_value, set_point (from bit 0), zero padded
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // in_tuser: mode
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: drive, zero padded
  output logic [((FRAC_BITS+8)/8)*8-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pidc_pkg::*;

  localparam int ERR_W      = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int OUT_DATA_W = ((FRAC_BITS + 8) / 8) * 8;

  logic [GAIN_W-1:0]         gain_r;
  logic signed [BOUND_W-1:0] int_min_r;
  logic signed [BOUND_W-1:0] int_max_r;

  item_ctl_t                 s2_ctl;
  logic                      s2_ready;
  logic signed [ERR_W-1:0]   s2_err;
  logic [FRAC_BITS:0]        drive;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RESET;
      int_min_r <= INT_MIN_RESET;
      int_max_r <= INT_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:    gain_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_INT_MIN: int_min_r <= cfg_wdata[BOUND_W-1:0];
        CFG_INT_MAX: int_max_r <= cfg_wdata[BOUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pidc_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ERR_W        (ERR_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (mode_t'(in_tuser)),
    .in_pv    (signed'(in_tdata[SAMPLE_WIDTH-1:0])),
    .in_sp    (signed'(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .gain     (gain_r),
    .s2_ctl   (s2_ctl),
    .s2_ready (s2_ready),
    .s2_err   (s2_err)
  );

  pidc_update #(
    .FRAC_BITS (FRAC_BITS),
    .ERR_W     (ERR_W)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_ctl    (s2_ctl),
    .s2_ready  (s2_ready),
    .s2_err    (s2_err),
    .int_min   (int_min_r),
    .int_max   (int_max_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .drive     (drive)
  );

  assign out_tdata = OUT_DATA_W'(drive);

endmodule

[hw/rtl/pidc_front.sv]
// Input register and error multiply stage of the PID step engine.
module pidc_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ERR_W        = 41
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pidc_pkg::mode_t              in_mode,
  input  logic signed [SAMPLE_WIDTH-1:0] in_pv,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sp,
  input  logic [pidc_pkg::GAIN_W-1:0]  gain,
  output pidc_pkg::item_ctl_t          s2_ctl,
  input  logic                         s2_ready,
  output logic signed [ERR_W-1:0]      s2_err
);
  import pidc_pkg::*;

  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;

  logic                          v1_r;
  mode_t                         mode1_r;
  logic signed [SAMPLE_WIDTH-1:0] pv1_r;
  logic signed [SAMPLE_WIDTH-1:0] sp1_r;
  logic                          v2_r;
  mode_t                         mode2_r;
  logic signed [ERR_W-1:0]       err2_r;

  logic                          en1;
  logic                          en2;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign en2      = !v2_r || s2_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Error and gain product from the registered samples
  assign diff = signed'({sp1_r[SAMPLE_WIDTH-1], sp1_r}) - signed'({pv1_r[SAMPLE_WIDTH-1], pv1_r});
  assign prod = diff * signed'({1'b0, gain});

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1 && in_valid) begin
      mode1_r <= in_mode;
      pv1_r   <= in_pv;
      sp1_r   <= in_sp;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2 && v1_r) begin
      mode2_r <= mode1_r;
      err2_r  <= prod[ERR_W-1:0];
    end
  end

  assign s2_ctl.valid = v2_r;
  assign s2_ctl.mode  = mode2_r;
  assign s2_err       = err2_r;

endmodule

[hw/rtl/pidc_update.sv]
// State update and output register of the PID step engine.
`include "assert_macros.svh"
module pidc_update #(
  parameter int FRAC_BITS = 16,
  parameter int ERR_W     = 41
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pidc_pkg::item_ctl_t                  s2_ctl,
  output logic                                 s2_ready,
  input  logic signed [ERR_W-1:0]              s2_err,
  input  logic signed [pidc_pkg::BOUND_W-1:0]  int_min,
  input  logic signed [pidc_pkg::BOUND_W-1:0]  int_max,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [FRAC_BITS:0]                   drive
);
  import pidc_pkg::*;

  localparam int DER_W = ERR_W + 1;
  localparam int INT_W = BOUND_W + FRAC_BITS + 1;
  localparam int DRV_W = FRAC_BITS + 1;
  localparam int ACC_W = ((DER_W > INT_W) ? DER_W : INT_W) + 2;
  localparam int PAD_W = ACC_W - BOUND_W - FRAC_BITS;

  logic signed [ERR_W-1:0] scaled_error_r, scaled_error_nxt;
  logic signed [INT_W-1:0] integral_r, integral_nxt;
  logic signed [DER_W-1:0] deriv_r, deriv_nxt;
  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;
  logic [DRV_W-1:0]        drive_level_r, drive_level_nxt;
  logic                    out_valid_r;

  logic                    en3;
  logic                    take;
  logic signed [ACC_W-1:0] lo_w, hi_w, one_w;
  logic signed [ACC_W-1:0] run_sum, int_sum, int_ext;

  // Output slot moves when empty or being taken
  assign en3      = !out_valid_r || out_ready;
  assign s2_ready = en3;
  assign take     = s2_ctl.valid && en3;

  // Integral bounds scaled to fixed point
  assign lo_w  = signed'({{PAD_W{int_min[BOUND_W-1]}}, int_min, {FRAC_BITS{1'b0}}});
  assign hi_w  = signed'({{PAD_W{int_max[BOUND_W-1]}}, int_max, {FRAC_BITS{1'b0}}});
  assign one_w = signed'(ACC_W'(1) << FRAC_BITS);

  assign int_ext = ACC_W'(integral_r);
  assign run_sum = ACC_W'(s2_err) + int_ext + ACC_W'(deriv_r);
  assign int_sum = int_ext + ACC_W'(scaled_error_r);

  // Next state per action
  always_comb begin
    scaled_error_nxt = scaled_error_r;
    integral_nxt     = integral_r;
    deriv_nxt        = deriv_r;
    prev_err_nxt     = prev_err_r;
    drive_level_nxt  = drive_level_r;
    unique case (s2_ctl.mode)
      MODE_RUN: begin
        scaled_error_nxt = s2_err;
        if (run_sum < 0) begin
          drive_level_nxt = '0;
        end else if (run_sum > one_w) begin
          drive_level_nxt = one_w[DRV_W-1:0];
        end else begin
          drive_level_nxt = run_sum[DRV_W-1:0];
        end
      end
      MODE_INTEGRATE: begin
        // lower bound is tested first when the bounds are crossed
        priority if (int_sum < lo_w) begin
          integral_nxt = lo_w[INT_W-1:0];
        end else if (int_sum > hi_w) begin
          integral_nxt = hi_w[INT_W-1:0];
        end else begin
          integral_nxt = int_sum[INT_W-1:0];
        end
      end
      MODE_DIFF: begin
        deriv_nxt    = DER_W'(scaled_error_r) - DER_W'(prev_err_r);
        prev_err_nxt = scaled_error_r;
      end
      MODE_RESTART: begin
        scaled_error_nxt = '0;
        integral_nxt     = '0;
        deriv_nxt        = '0;
        prev_err_nxt     = '0;
        drive_level_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // Controller state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaled_error_r <= '0;
      integral_r     <= '0;
      deriv_r        <= '0;
      prev_err_r     <= '0;
      drive_level_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (en3) begin
        out_valid_r <= s2_ctl.valid;
      end
      if (take) begin
        scaled_error_r <= scaled_error_nxt;
        integral_r     <= integral_nxt;
        deriv_r        <= deriv_nxt;
        prev_err_r     <= prev_err_nxt;
        drive_level_r  <= drive_level_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign drive     = drive_level_r;

  `ASSERT_CLK(a_drive_range, ACC_W'(drive_level_r) <= one_w, "drive above full scale")
  `ASSERT_CLK(a_restart_clears, (take && s2_ctl.mode == MODE_RESTART) |=> (drive_level_r == '0 && integral_r == '0 && deriv_r == '0), "restart left state")
  `ASSERT_CLK(a_int_bounds, (take && s2_ctl.mode == MODE_INTEGRATE && lo_w <= hi_w) |=> (int_ext >= $past(lo_w) && int_ext <= $past(hi_w)), "integral outside bounds")
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
